// File: hdl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants, codes and control types of the sprite scanline counter.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Number of entries in the sprite table (1 to 512).
  localparam int SPRITE_COUNT = 382;
  localparam int ADDR_W       = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int CNT_W        = $clog2(SPRITE_COUNT + 1);

  // Fixed field widths.
  localparam int WORD_W  = 16;
  localparam int IDX_W   = 9;
  localparam int LINE_W  = 8;
  localparam int VAL_W   = 9;
  localparam int HGT_W   = 6;
  localparam int CFG_IDX_W = 2;

  // Control word layout.
  localparam int Y_MSB      = 15;
  localparam int Y_LSB      = 7;
  localparam int STICKY_POS = 6;

  localparam logic [VAL_W-1:0] LINE_OFFSET    = 9'd32;
  localparam logic [VAL_W-1:0] DEFAULT_LIMIT  = 9'd96;
  localparam logic [VAL_W-1:0] DEFAULT_WIDTH  = 9'd320;
  localparam logic [VAL_W-1:0] DEFAULT_HEIGHT = 9'd224;

  // The bar dividend is a 9-bit count times a 9-bit width.
  localparam int DIV_W  = 2 * VAL_W;
  localparam int DIVC_W = $clog2(DIV_W);

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  typedef struct packed {
    logic wr;
    logic query_load;
    logic scan_rd;
    logic div_init;
    logic div_step;
    logic out_load;
  } ssc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
  } ssc_status_t;

  function automatic logic [VAL_W-1:0] sat9(input logic [CNT_W-1:0] v);
    logic [CNT_W:0] wide;
    wide = {1'b0, v};
    if (wide > (CNT_W+1)'(511)) begin
      return 9'h1ff;
    end
    return VAL_W'(v);
  endfunction

endpackage

// File: hdl/ssc_ram.sv
// ----------------------------------------------------------------------------
// ssc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ssc_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 382,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer of the sprite scanline counter: handshakes, table walk and
// bar division steps.
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  output logic                out_valid,
  input  logic                out_ready,
  output ssc_pkg::ssc_cmd_t    cmd,
  input  ssc_pkg::ssc_status_t status
);
  import ssc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_DRAIN   = 6'b000100,
    S_DIVINIT = 6'b001000,
    S_DIV     = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == REQ_QUERY) begin
            cmd.query_load = 1'b1;
            state_next     = S_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // The last table word comes out of the RAM in this cycle.
      S_DRAIN: begin
        state_next = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/ssc_datapath.sv
// ----------------------------------------------------------------------------
// ssc_datapath
// Sprite table, configuration registers, per-sprite line and chain counting,
// restoring divider for the bar and the result registers.
// ----------------------------------------------------------------------------
module ssc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ssc_pkg::ssc_cmd_t             cmd,
  output ssc_pkg::ssc_status_t          status,
  input  logic                         cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssc_pkg::VAL_W-1:0]     cfg_data,
  input  logic [ssc_pkg::IDX_W-1:0]     sprite_index,
  input  logic [ssc_pkg::WORD_W-1:0]    control_word,
  input  logic [ssc_pkg::LINE_W-1:0]    scan_line,
  input  logic                         frame_start,
  output logic [ssc_pkg::VAL_W-1:0]     line_count,
  output logic [ssc_pkg::VAL_W-1:0]     bar_length,
  output logic                         over_limit,
  output logic [ssc_pkg::VAL_W-1:0]     max_count,
  output logic [ssc_pkg::VAL_W-1:0]     chain_total,
  output logic                         active_over
);
  import ssc_pkg::*;

  // Configuration.
  logic [VAL_W-1:0] screen_height, screen_width, sprite_limit;
  logic [VAL_W-1:0] height_eff, width_eff, limit_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= DEFAULT_HEIGHT;
      screen_width  <= DEFAULT_WIDTH;
      sprite_limit  <= DEFAULT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT: screen_height <= cfg_data;
        CFG_WIDTH:  screen_width  <= cfg_data;
        CFG_LIMIT:  sprite_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign height_eff = (screen_height == '0) ? DEFAULT_HEIGHT : screen_height;
  assign width_eff  = (screen_width == '0)  ? DEFAULT_WIDTH  : screen_width;
  assign limit_eff  = (sprite_limit == '0)  ? DEFAULT_LIMIT  : sprite_limit;

  // Sprite table. Writes past the end of the table are dropped.
  logic              tbl_we;
  logic [ADDR_W-1:0] scan_addr;
  logic [WORD_W-1:0] rd_word;

  assign tbl_we = cmd.wr && ({1'b0, sprite_index} < (IDX_W+1)'(SPRITE_COUNT));

  ssc_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (SPRITE_COUNT),
    .AW     (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (sprite_index[ADDR_W-1:0]),
    .wdata (control_word),
    .raddr (scan_addr),
    .rdata (rd_word)
  );

  // Table walk.
  logic              dv, first;
  logic [LINE_W-1:0] line_q;
  logic              fstart_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else begin
      dv <= cmd.scan_rd;
    end
    first <= cmd.scan_rd && (scan_addr == '0);
    if (cmd.query_load) begin
      scan_addr <= '0;
      line_q    <= scan_line;
      fstart_q  <= frame_start;
    end else if (cmd.scan_rd) begin
      scan_addr <= scan_addr + ADDR_W'(1);
    end
  end

  assign status.scan_last = (scan_addr == ADDR_W'(SPRITE_COUNT - 1));

  logic [VAL_W-1:0] head_y, hy, w_y, row;
  logic [HGT_W-1:0] head_h, hh, w_h;
  logic             w_sticky, hit, act_flag, act_next;
  logic [CNT_W-1:0] count, active;

  assign w_y      = rd_word[Y_MSB:Y_LSB];
  assign w_h      = rd_word[HGT_W-1:0];
  assign w_sticky = rd_word[STICKY_POS];
  assign hy       = (first || !w_sticky) ? w_y : head_y;
  assign hh       = (first || !w_sticky) ? w_h : head_h;
  // The row wraps at 512 lines.
  assign row      = {1'b0, line_q} + LINE_OFFSET + hy;
  assign hit      = (hh != '0) && ({1'b0, row} < {hh, 4'b0000});
  // A sticky run at the start of the table belongs to no chain.
  assign act_next = w_sticky ? act_flag : ((w_h != '0) && (w_y != height_eff));

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      count    <= '0;
      active   <= '0;
      act_flag <= 1'b0;
    end else if (dv) begin
      head_y   <= hy;
      head_h   <= hh;
      act_flag <= act_next;
      count    <= count + CNT_W'(hit);
      active   <= active + CNT_W'(act_next);
    end
  end

  // Bar length: restoring divider, one quotient bit a cycle.
  logic [VAL_W-1:0]  count9;
  logic [DIV_W-1:0]  quo;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W:0]    trial;
  logic [DIVC_W-1:0] div_cnt;
  logic              fits;

  assign count9 = sat9(count);
  assign trial  = {rem, quo[DIV_W-1]};
  assign fits   = trial >= {1'b0, limit_eff};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo     <= count9 * width_eff;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quo     <= {quo[DIV_W-2:0], fits};
      rem     <= fits ? VAL_W'(trial - {1'b0, limit_eff}) : VAL_W'(trial);
      div_cnt <= div_cnt + DIVC_W'(1);
    end
  end

  assign status.div_last = (div_cnt == DIVC_W'(DIV_W - 1));

  // Running maximum and results.
  logic [VAL_W-1:0] running_max, max_base, max_next;

  assign max_base = fstart_q ? '0 : running_max;
  assign max_next = (count9 > max_base) ? count9 : max_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (cmd.out_load) begin
      running_max <= max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      line_count  <= count9;
      bar_length  <= (quo > DIV_W'(width_eff)) ? width_eff : quo[VAL_W-1:0];
      over_limit  <= max_next > limit_eff;
      max_count   <= max_next;
      chain_total <= sat9(active);
      active_over <= {1'b0, active} > (CNT_W+1)'(SPRITE_COUNT - 1);
    end
  end

endmodule

// File: hdl/sprite_scanline_counter.sv
// ----------------------------------------------------------------------------
// sprite_scanline_counter
// Sprite vertical-control table with per-scanline sprite count, bar length,
// running maximum and active chain total.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Word
//  in        input      in_valid / in_ready   req_type, sprite_index,
//                                             control_word, scan_line,
//                                             frame_start
//  out       output     out_valid / out_ready line_count, bar_length,
//                                             over_limit, max_count,
//                                             chain_total, active_over
//  cfg       input      cfg_we                cfg_index, cfg_data
//
//  A write word is stored in the cycle it is accepted and gives no result.
//  A line query reads the table once per sprite through the single RAM read
//  port, then the bar divider works out one quotient bit per cycle, then the
//  result registers load once the previous result has been taken.
//  While a query runs no input word is accepted; a finished result waits in
//  the output registers, and new words are taken while it waits.
//  Reset (rst, synchronous) restores the configuration defaults and clears
//  the running maximum; the sprite table holds no defined value until written.
//
module sprite_scanline_counter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [ssc_pkg::IDX_W-1:0]     sprite_index,
  input  logic [ssc_pkg::WORD_W-1:0]    control_word,
  input  logic [ssc_pkg::LINE_W-1:0]    scan_line,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ssc_pkg::VAL_W-1:0]     line_count,
  output logic [ssc_pkg::VAL_W-1:0]     bar_length,
  output logic                         over_limit,
  output logic [ssc_pkg::VAL_W-1:0]     max_count,
  output logic [ssc_pkg::VAL_W-1:0]     chain_total,
  output logic                         active_over,
  input  logic                         cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssc_pkg::VAL_W-1:0]     cfg_data
);
  import ssc_pkg::*;

  ssc_cmd_t    cmd;
  ssc_status_t status;

  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  ssc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sprite_index (sprite_index),
    .control_word (control_word),
    .scan_line    (scan_line),
    .frame_start  (frame_start),
    .line_count   (line_count),
    .bar_length   (bar_length),
    .over_limit   (over_limit),
    .max_count    (max_count),
    .chain_total  (chain_total),
    .active_over  (active_over)
  );

  // An accepted query keeps the input side closed until its result is loaded.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_QUERY) |=> !in_ready)
    else $error("input accepted while a line query was starting");

  // The walk stops after the last table entry.
  a_scan_stop: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd && status.scan_last |=> !cmd.scan_rd)
    else $error("table walk ran past the last entry");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a word not yet taken");

  // A result appears only from a result load.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("out_valid rose without a result load");

endmodule
